[sv/fpfa_pkg.sv]
// Shared payload types and codes for the fixed-partition fit allocator.
package fpfa_pkg;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_REQUEST = 1'b1;

  localparam logic [1:0] POLICY_FIRST = 2'd0;
  localparam logic [1:0] POLICY_BEST  = 2'd1;
  localparam logic [1:0] POLICY_WORST = 2'd2;

  localparam logic CFG_FIT_POLICY      = 1'b0;
  localparam logic CFG_PARTITION_COUNT = 1'b1;

  localparam logic [4:0] PARTITION_COUNT_RESET = 5'd16;

  typedef struct packed {
    logic        cmd;
    logic [3:0]  slot;
    logic [15:0] amount;
  } in_item_t;

  typedef struct packed {
    logic       granted;
    logic [3:0] chosen_slot;
  } out_item_t;

endpackage

[sv/fpfa_cell.sv]
// One partition cell: holds a size and a used mark and advances the search token.
module fpfa_cell #(
  parameter int  INDEX     = 0,
  parameter int  IDX_W     = 4,
  parameter int  SIZE_BITS = 16,
  parameter int  CMP_W     = 16,
  parameter type token_t   = logic,
  parameter type ctl_t     = logic
) (
  input  logic   clk,
  input  logic   rst,
  input  ctl_t   ctl,
  input  logic   tok_valid_in,
  input  token_t tok_in,
  output logic   tok_valid_out,
  output token_t tok_out
);
  import fpfa_pkg::*;

  logic [SIZE_BITS-1:0] size;
  logic                 used;
  logic                 hit;
  logic                 eligible;
  logic                 take;
  token_t               tok_next;

  assign hit = (ctl.idx == IDX_W'(INDEX));

  always_ff @(posedge clk) begin
    if (ctl.ld_en && hit) begin
      size <= ctl.size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else if (ctl.ld_en && hit) begin
      used <= 1'b0;
    end else if (ctl.mark_en && hit) begin
      used <= 1'b1;
    end
  end

  assign eligible = (32'(INDEX) < 32'(tok_in.limit)) && !used &&
                    (CMP_W'(size) >= tok_in.amount);

  always_comb begin
    take = 1'b0;
    if (eligible) begin
      priority if (!tok_in.found) begin
        take = 1'b1;
      end else if (tok_in.policy == POLICY_BEST) begin
        take = (size < tok_in.pick_size);
      end else if (tok_in.policy == POLICY_WORST) begin
        take = (size > tok_in.pick_size);
      end else begin
        take = 1'b0;
      end
    end
    tok_next = tok_in;
    if (take) begin
      tok_next.found     = 1'b1;
      tok_next.pick      = IDX_W'(INDEX);
      tok_next.pick_size = size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid_out <= 1'b0;
    end else begin
      tok_valid_out <= tok_valid_in;
    end
  end

  always_ff @(posedge clk) begin
    tok_out <= tok_next;
  end

endmodule

[sv/fixed_partition_fit_allocator.sv]
// Top level of the fixed-partition fit allocator: a chain of partition cells.
//
// Items arrive on in_valid/in_stall/in_data and results leave on
// out_valid/out_stall/out_data; each item gives exactly one result.
// A load item with a slot below MAX_PARTITIONS writes that partition's
// size and frees it. Its result is registered in the cycle after the
// transfer, and loads can follow each other every cycle while the output
// is being taken. A request sends a search token down the row of
// MAX_PARTITIONS cells, one cell per cycle. Each cell registers the token,
// and the result is registered from the token that leaves the last cell.
// No further item is taken until the search has finished.
// The configuration port writes fit_policy (index 0) or partition_count
// (index 1) on any cycle with cfg_write high; write only while idle.
// Reset frees every partition, sets first fit and a count of 16, and empties
// the output register. Sizes are unknown until loaded.
// While the receiver stalls, the result holds and in_stall rises so that no
// further item is taken until the result has been transferred.
module fixed_partition_fit_allocator #(
  parameter int MAX_PARTITIONS = 16,
  parameter int SIZE_BITS      = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  fpfa_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output fpfa_pkg::out_item_t out_data,
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic [4:0]          cfg_data
);
  import fpfa_pkg::*;

  localparam int IDX_W = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
  localparam int CNT_W = $clog2(MAX_PARTITIONS + 1);
  localparam int CMP_W = (SIZE_BITS > 16) ? SIZE_BITS : 16;

  typedef struct packed {
    logic                 found;
    logic [IDX_W-1:0]     pick;
    logic [SIZE_BITS-1:0] pick_size;
    logic [CMP_W-1:0]     amount;
    logic [1:0]           policy;
    logic [CNT_W-1:0]     limit;
  } token_t;

  typedef struct packed {
    logic                 ld_en;
    logic                 mark_en;
    logic [IDX_W-1:0]     idx;
    logic [SIZE_BITS-1:0] size;
  } ctl_t;

  logic [1:0] fit_policy;
  logic [4:0] partition_count;
  logic       busy;
  logic       accept;
  logic       is_load;
  logic       is_request;
  logic       slot_ok;
  logic       done;

  logic   tok_valid [MAX_PARTITIONS+1];
  token_t tok       [MAX_PARTITIONS+1];
  ctl_t   ctl;

  out_item_t out_next;
  logic      out_load;

  assign in_stall   = busy || (out_valid && out_stall);
  assign accept     = in_valid && !in_stall;
  assign is_load    = accept && (in_data.cmd == CMD_LOAD);
  assign is_request = accept && (in_data.cmd == CMD_REQUEST);
  assign slot_ok    = (32'(in_data.slot) < 32'(MAX_PARTITIONS));
  assign done       = tok_valid[MAX_PARTITIONS];

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_policy      <= POLICY_FIRST;
      partition_count <= PARTITION_COUNT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_FIT_POLICY:      fit_policy      <= cfg_data[1:0];
        CFG_PARTITION_COUNT: partition_count <= cfg_data;
        default:             fit_policy      <= fit_policy;
      endcase
    end
  end

  always_comb begin
    tok_valid[0]        = is_request;
    tok[0].found        = 1'b0;
    tok[0].pick         = '0;
    tok[0].pick_size    = '0;
    tok[0].amount       = CMP_W'(in_data.amount);
    tok[0].policy       = fit_policy;
    if (32'(partition_count) > 32'(MAX_PARTITIONS)) begin
      tok[0].limit = CNT_W'(MAX_PARTITIONS);
    end else begin
      tok[0].limit = CNT_W'(partition_count);
    end
  end

  // Loads and the used mark of a finished search share one broadcast; the
  // search holds off all items, so the two never coincide.
  always_comb begin
    ctl.ld_en   = is_load && slot_ok;
    ctl.mark_en = done && tok[MAX_PARTITIONS].found;
    ctl.size    = SIZE_BITS'(in_data.amount);
    if (done) begin
      ctl.idx = tok[MAX_PARTITIONS].pick;
    end else begin
      ctl.idx = IDX_W'(in_data.slot);
    end
  end

  for (genvar i = 0; i < MAX_PARTITIONS; i++) begin : g_cell
    fpfa_cell #(
      .INDEX    (i),
      .IDX_W    (IDX_W),
      .SIZE_BITS(SIZE_BITS),
      .CMP_W    (CMP_W),
      .token_t  (token_t),
      .ctl_t    (ctl_t)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctl          (ctl),
      .tok_valid_in (tok_valid[i]),
      .tok_in       (tok[i]),
      .tok_valid_out(tok_valid[i+1]),
      .tok_out      (tok[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (is_request) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  always_comb begin
    out_load = is_load || done;
    out_next = '0;
    if (done) begin
      if (tok[MAX_PARTITIONS].found) begin
        out_next.granted     = 1'b1;
        out_next.chosen_slot = 4'(tok[MAX_PARTITIONS].pick);
      end
    end else if (slot_ok) begin
      out_next.granted     = 1'b1;
      out_next.chosen_slot = in_data.slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= out_next;
    end
  end

endmodule
